FILE: rtl/slfa_pkg.sv
// ----------------------------------------------------------------------------
// slfa_pkg
// Shared types and constants for the slot free-list allocator: the input
// and result words, mode codes, controller states, and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package slfa_pkg;

    // fixed width of the slot fields in the words
    localparam int SLOT_W = 10;

    // default number of slots in the store
    localparam int SLOT_COUNT_DEF = 1024;

    // request codes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // input word
    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot_index;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              ok;
    } t_out_word;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;     // take the input word and update state
        logic load_head;  // head takes the link read from the store
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop;        // current request pops the free list
    } t_dp_status;

endpackage

FILE: rtl/slfa_datapath.sv
// ----------------------------------------------------------------------------
// slfa_datapath
// Head and bump registers, the link store and the result register.
// Works out each request in the cycle it is taken; a pop reads the head's
// link from the store and loads it into the head in the following cycle.
// ----------------------------------------------------------------------------
module slfa_datapath #(
    parameter int SLOT_COUNT = slfa_pkg::SLOT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  slfa_pkg::t_ctrl_cmd   i_cmd,
    input  slfa_pkg::t_in_word    i_in_word,
    output slfa_pkg::t_dp_status  o_status,
    output slfa_pkg::t_out_word   o_out_word
);

    localparam int PTR_W = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CMP_W = ((PTR_W > slfa_pkg::SLOT_W) ? PTR_W : slfa_pkg::SLOT_W) + 1;
    localparam logic [PTR_W-1:0] SLOT_LIMIT = PTR_W'(SLOT_COUNT);
    localparam logic [CMP_W-1:0] SLOT_LIMIT_CMP = CMP_W'(SLOT_COUNT);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_bump, n_bump;
    logic [PTR_W-1:0] r_rd_data;
    logic [PTR_W-1:0] r_link_mem [SLOT_COUNT];
    slfa_pkg::t_out_word r_out_word, n_out_word;

    logic             list_empty;
    logic [CMP_W-1:0] slot_cmp;
    logic [CMP_W-1:0] head_cmp;
    logic             slot_valid;
    logic             mem_wr;
    logic             mem_rd;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    assign list_empty = (r_head == r_bump);
    assign slot_cmp   = CMP_W'(i_in_word.slot_index);
    assign head_cmp   = CMP_W'(r_head);
    assign slot_valid = (slot_cmp < SLOT_LIMIT_CMP);
    assign wr_addr    = IDX_W'(i_in_word.slot_index);
    assign rd_addr    = IDX_W'(r_head);

    // pop: allocate from a non-empty list with a sane head
    assign o_status.pop = (i_in_word.mode == slfa_pkg::MODE_ALLOC) && !list_empty
                          && (r_head < SLOT_LIMIT);

    // request decode
    always_comb begin
        n_head     = r_head;
        n_bump     = r_bump;
        n_out_word = '0;
        mem_wr     = 1'b0;
        mem_rd     = 1'b0;
        if (i_cmd.load_head) begin
            n_head = r_rd_data;
        end else if (i_cmd.accept) begin
            if (i_in_word.mode == slfa_pkg::MODE_ALLOC) begin
                if (list_empty) begin
                    // fresh slot from the bump pointer unless exhausted
                    if (r_bump < SLOT_LIMIT) begin
                        n_bump                  = r_bump + PTR_W'(1);
                        n_head                  = r_bump + PTR_W'(1);
                        n_out_word.granted_slot = slfa_pkg::SLOT_W'(r_bump);
                        n_out_word.ok           = 1'b1;
                    end
                end else if (r_head < SLOT_LIMIT) begin
                    // pop: link is loaded next cycle
                    mem_rd                  = 1'b1;
                    n_out_word.granted_slot = slfa_pkg::SLOT_W'(r_head);
                    n_out_word.ok           = 1'b1;
                end
            end else if (slot_valid) begin
                n_out_word.ok = 1'b1;
                if (list_empty && (slot_cmp + CMP_W'(1) == head_cmp)) begin
                    // slot just below bump: retreat
                    n_bump = PTR_W'(i_in_word.slot_index);
                    n_head = PTR_W'(i_in_word.slot_index);
                end else begin
                    // push onto the free list
                    mem_wr = 1'b1;
                    n_head = PTR_W'(i_in_word.slot_index);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_bump <= '0;
        end else begin
            r_head <= n_head;
            r_bump <= n_bump;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_word <= n_out_word;
        end
    end

    // link store
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_link_mem[wr_addr] <= r_head;
        end
        if (mem_rd) begin
            r_rd_data <= r_link_mem[rd_addr];
        end
    end

    assign o_out_word = r_out_word;

`ifndef ASSERT_OFF
    // bump pointer never passes the end of the store
    a_bump_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump <= SLOT_LIMIT)
        else $error("bump pointer beyond store");

    // a head load always follows a store read
    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_head |-> $past(mem_rd))
        else $error("head loaded without link read");

    // a valid free leaves the freed slot at the head
    a_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && (i_in_word.mode == slfa_pkg::MODE_FREE) && slot_valid
        |=> r_head == $past(PTR_W'(i_in_word.slot_index)))
        else $error("freed slot not at head");
`endif

endmodule

FILE: rtl/slfa_ctrl.sv
// ----------------------------------------------------------------------------
// slfa_ctrl
// Controller for the slot allocator: takes input words, holds the result
// valid until it is taken, and passes through the pop state on a pop while the
// head's link comes back from the store.
// ----------------------------------------------------------------------------
module slfa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_stall,
    input  slfa_pkg::t_dp_status  i_status,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output slfa_pkg::t_ctrl_cmd   o_cmd
);

    slfa_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             accept;

    assign accept = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slfa_pkg::S_IDLE: begin
                if (accept && i_status.pop) begin
                    n_state = slfa_pkg::S_POP;
                end
            end
            slfa_pkg::S_POP: begin
                n_state = slfa_pkg::S_IDLE;
            end
            default: begin
                n_state = slfa_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall      = 1'b1;
        o_cmd.load_head = 1'b0;
        case (r_state)
            slfa_pkg::S_IDLE: begin
                o_in_stall = r_out_valid && i_out_stall;
            end
            slfa_pkg::S_POP: begin
                o_cmd.load_head = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        o_cmd.accept = i_in_valid && !o_in_stall;
    end

    // result valid: set on accept, cleared once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slfa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // the pop state always returns straight to idle
    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == slfa_pkg::S_POP |=> r_state == slfa_pkg::S_IDLE)
        else $error("pop state held too long");

    // an accepted pop enters the pop state
    a_pop_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_status.pop |=> r_state == slfa_pkg::S_POP)
        else $error("pop not followed by link load");

    // every accepted word leaves a result waiting
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word gave no result");
`endif

endmodule

FILE: rtl/slot_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_free_list_allocator_top
// Allocator of fixed-size slots with a bump pointer and a LIFO free list.
// ----------------------------------------------------------------------------
// Each word gives exactly one result word. Allocates from the bump pointer,
// frees, and failed requests need no extra state; an allocate that pops the
// free list passes through the pop state, since the head's link is read from
// the single link store with registered read data before the new head is
// known. The result sits in an output register, and the next word is taken
// while it waits unless the output side stalls with a result still held.
// The link store holds no reset value and needs no clearing after reset.
// ----------------------------------------------------------------------------
module slot_free_list_allocator_top #(
    parameter int SLOT_COUNT = slfa_pkg::SLOT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  slfa_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output slfa_pkg::t_out_word  o_out_word
);

    slfa_pkg::t_ctrl_cmd  cmd;
    slfa_pkg::t_dp_status status;

    // controller
    slfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath
    slfa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slot free-list allocator. A queue of request
// words is planned up front: a directed opening, then random allocate and
// free traffic with some misuse. A clocked driver presents the words with
// random gaps and a clocked monitor takes results with random stalls. Every
// accepted word is run through a behavioural pool model and the result is
// compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          SLOTS        = slfa_pkg::SLOT_COUNT_DEF;
    localparam int          RANDOM_WORDS = 578;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned SETTLE       = 20;

    // pool model copies: one steers planning, one predicts the results
    localparam int unsigned PLAN  = 0;
    localparam int unsigned SCORE = 1;

    typedef struct packed {
        slfa_pkg::t_in_word word;
        logic               hold_off;   // wait until every result is back first
    } t_req;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    slfa_pkg::t_in_word  in_word   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    slfa_pkg::t_out_word out_word;

    // pool model state
    logic [10:0] pool_head  [2];
    logic [10:0] pool_bump  [2];
    logic [10:0] pool_link  [2][SLOTS];
    bit          pool_known [2][SLOTS];

    // planning bookkeeping
    t_req        pending_words [$];
    logic [9:0]  held_slots [$];
    logic [9:0]  last_freed = '0;
    int unsigned plan_total = 0;

    // expected results and progress counters
    slfa_pkg::t_out_word due_grants [$];
    int unsigned words_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned errors        = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    int unsigned in_calm       = 0;
    int unsigned out_calm      = 0;
    int unsigned cycle_count   = 0;
    int unsigned count_grants  = 0;
    int unsigned count_refused = 0;
    int unsigned count_frees   = 0;

    slot_free_list_allocator_top #(
        .SLOT_COUNT (SLOTS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // one word through the pool model, updating copy k
    function automatic slfa_pkg::t_out_word pool_apply(input int unsigned k,
                                                       input slfa_pkg::t_in_word w);
        slfa_pkg::t_out_word r;
        logic [10:0]         s;
        r = '0;
        s = {1'b0, w.slot_index};
        if (w.mode == slfa_pkg::MODE_ALLOC) begin
            if (pool_head[k] == pool_bump[k]) begin
                // empty list: take from the bump pointer unless the store is full
                if (pool_bump[k] < SLOTS) begin
                    r.granted_slot = pool_bump[k][9:0];
                    r.ok           = 1'b1;
                    pool_bump[k]   = pool_bump[k] + 11'd1;
                    pool_head[k]   = pool_bump[k];
                end
            end else if (pool_head[k] < SLOTS) begin
                // pop the head and follow its link
                r.granted_slot = pool_head[k][9:0];
                r.ok           = 1'b1;
                pool_head[k]   = pool_link[k][pool_head[k][9:0]];
            end
        end else if (s < SLOTS) begin
            r.ok = 1'b1;
            if (pool_head[k] == pool_bump[k] && s + 11'd1 == pool_head[k]) begin
                // top slot back on an empty list: bump pointer retreats
                pool_bump[k] = s;
                pool_head[k] = s;
            end else begin
                pool_link[k][s[9:0]]  = pool_head[k];
                pool_known[k][s[9:0]] = 1'b1;
                pool_head[k]          = s;
            end
        end
        return r;
    endfunction

    // idle or stall length for one word, with calm stretches of none
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        if ($urandom_range(0, 1) == 0) begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(0, 19);
    endfunction

    // queue one request word, steering clear of a pop of a never-written link
    task automatic plan_word(input logic mode, input logic [9:0] slot, input logic hold_off);
        slfa_pkg::t_in_word  w;
        slfa_pkg::t_out_word r;
        t_req                q;
        w.mode       = mode;
        w.slot_index = slot;
        if (mode == slfa_pkg::MODE_ALLOC && pool_head[PLAN] != pool_bump[PLAN]
                && pool_head[PLAN] < SLOTS && !pool_known[PLAN][pool_head[PLAN][9:0]]) begin
            if (pool_bump[PLAN] >= SLOTS) begin
                return;
            end
            // freeing the bump slot empties the list instead
            w.mode       = slfa_pkg::MODE_FREE;
            w.slot_index = pool_bump[PLAN][9:0];
        end
        r = pool_apply(PLAN, w);
        if (w.mode == slfa_pkg::MODE_ALLOC) begin
            if (r.ok) begin
                held_slots = {held_slots, r.granted_slot};
            end
        end else begin
            for (int i = 0; i < held_slots.size(); i++) begin
                if (held_slots[i] == w.slot_index) begin
                    held_slots.delete(i);
                    break;
                end
            end
            last_freed = w.slot_index;
        end
        q.word        = w;
        q.hold_off    = hold_off;
        pending_words = {pending_words, q};
    endtask

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // request side: present planned words with random gaps
    always @(posedge clk) begin : drive
        logic                take;
        int unsigned         wait_now;
        int unsigned         taken_now;
        t_req                nxt;
        slfa_pkg::t_out_word res;
        take      = in_valid && !in_stall;
        taken_now = words_taken + (take ? 1 : 0);
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            // predict the result of the word just taken
            if (take) begin
                res        = pool_apply(SCORE, in_word);
                due_grants = {due_grants, res};
                if (in_word.mode == slfa_pkg::MODE_FREE) begin
                    count_frees = count_frees + 1;
                end else if (res.ok) begin
                    count_grants = count_grants + 1;
                end else begin
                    count_refused = count_refused + 1;
                end
                words_taken <= taken_now;
            end
            // next word once the bus is free and the gap has run out
            if (take || !in_valid) begin
                wait_now = take ? draw_wait(in_calm) : gap_left;
                if (wait_now != 0) begin
                    gap_left <= wait_now - 1;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0
                        && (!pending_words[0].hold_off || taken_now == results_seen)) begin
                    nxt = pending_words.pop_front();
                    in_word  <= nxt.word;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side: take results with random stalls and check them in order
    always @(posedge clk) begin : watch
        slfa_pkg::t_out_word want;
        int unsigned         w;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (results_seen >= words_taken) begin
                $error("result with no request outstanding: granted_slot %0d ok %0b",
                       out_word.granted_slot, out_word.ok);
                errors = errors + 1;
            end else begin
                want = due_grants.pop_front();
                if (out_word.granted_slot !== want.granted_slot) begin
                    $error("granted_slot: expected %0d, got %0d",
                           want.granted_slot, out_word.granted_slot);
                    errors = errors + 1;
                end
                if (out_word.ok !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, out_word.ok);
                    errors = errors + 1;
                end
            end
            w = draw_wait(out_calm);
            stall_left <= w;
            out_stall  <= (w != 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
    end

    // plan the stimulus, run reset, wait for the end and report
    initial begin : run
        int unsigned pick;
        logic        hold;
        logic [9:0]  slot;

        for (int k = 0; k < 2; k++) begin
            pool_head[k] = '0;
            pool_bump[k] = '0;
            for (int i = 0; i < SLOTS; i++) begin
                pool_link[k][i]  = '0;
                pool_known[k][i] = 1'b0;
            end
        end

        // directed opening: bump grants, retreat, pushes and back-to-back pops
        plan_word(slfa_pkg::MODE_ALLOC, 10'h3FF, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        plan_word(slfa_pkg::MODE_FREE,  10'd3,   1'b0);
        plan_word(slfa_pkg::MODE_FREE,  10'd0,   1'b0);
        plan_word(slfa_pkg::MODE_FREE,  10'd2,   1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        // slot never handed out, then a double free that loops the list
        plan_word(slfa_pkg::MODE_FREE,  10'h3FF, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        plan_word(slfa_pkg::MODE_FREE,  10'd1,   1'b0);
        plan_word(slfa_pkg::MODE_FREE,  10'd1,   1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);
        // free of the bump slot itself leaves the list empty
        plan_word(slfa_pkg::MODE_FREE,  10'd4,   1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h2AA, 1'b0);
        plan_word(slfa_pkg::MODE_FREE,  10'h155, 1'b0);
        plan_word(slfa_pkg::MODE_FREE,  10'h2AA, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h155, 1'b0);
        plan_word(slfa_pkg::MODE_ALLOC, 10'h000, 1'b0);

        // random traffic, mostly allocates and frees of slots actually held
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            hold = (n == 0) || ($urandom_range(0, 199) == 0);
            if (pick < 52 || held_slots.size() == 0) begin
                plan_word(slfa_pkg::MODE_ALLOC, 10'($urandom), hold);
            end else if (pick < 93) begin
                if ($urandom_range(0, 2) == 0) begin
                    slot = held_slots[held_slots.size() - 1];
                end else begin
                    slot = held_slots[$urandom_range(0, held_slots.size() - 1)];
                end
                plan_word(slfa_pkg::MODE_FREE, slot, hold);
            end else begin
                // misuse: any slot, a double free, or the bump slot
                case ($urandom_range(0, 2))
                    0: begin
                        slot = 10'($urandom);
                    end
                    1: begin
                        slot = last_freed;
                    end
                    default: begin
                        slot = pool_bump[PLAN][9:0];
                    end
                endcase
                plan_word(slfa_pkg::MODE_FREE, slot, hold);
            end
        end
        plan_total = pending_words.size();

        // hold synchronous reset, then release it
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // every word taken and every result back, then let things settle
        do begin
            @(posedge clk);
        end while (words_taken != plan_total || results_seen != words_taken);
        repeat (SETTLE) @(posedge clk);

        if (due_grants.size() != 0) begin
            $error("%0d expected results never arrived", due_grants.size());
            errors = errors + 1;
        end
        $display("run covered %0d words: %0d slots granted, %0d allocates refused, %0d frees",
                 words_taken, count_grants, count_refused, count_frees);
        $display("bump grants, retreats, pops and misuse frees checked; %0d mismatches seen",
                 errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
